[design/epcm_pkg.sv]
// Shared constants, codes, types and the quarter-wave gain table of the crossfade mixer.
package epcm_pkg;

    // Item opcodes carried in the input tuser field.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_PLAY    = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
    localparam logic [OP_W-1:0] OP_XFADE   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLICK   = 3'd4;
    localparam logic [OP_W-1:0] OP_ACCENT  = 3'd5;
    localparam logic [OP_W-1:0] OP_OPEN    = 3'd6;
    localparam logic [OP_W-1:0] OP_PRELOAD = 3'd7;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_XFADE_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_EN    = 2'd2;

    // Step registers and master gain are Q24 values in 25 bits.
    localparam int STEP_W = 25;
    localparam logic [STEP_W-1:0] XFADE_STEP_RST  = 25'd175;
    localparam logic [STEP_W-1:0] MASTER_STEP_RST = 25'd524;
    localparam logic [STEP_W-1:0] GAIN_ONE        = 25'h100_0000;

    // Crossfade phase: 2^PHASE_BITS is a quarter turn.
    localparam int PHASE_BITS  = 24;
    localparam int PHASE_W     = PHASE_BITS + 1;
    localparam int PHASE_SUM_W = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;
    localparam logic [PHASE_W-1:0] PHASE_FULL = {1'b1, {PHASE_BITS{1'b0}}};

    // Q1.15 pad gains.
    localparam int GAIN_W = 16;
    localparam logic [GAIN_W-1:0] Q15_ONE = 16'h8000;

    // Quarter-wave table geometry.
    localparam int SINE_DEPTH = 256;
    localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
    localparam int SINE_AW    = SINE_IDX_W + 1;

    // Serial multiplier step counts.
    localparam int MUL_CNT_W = $clog2(STEP_W + 1);
    localparam logic [MUL_CNT_W-1:0] MUL1_STEPS = MUL_CNT_W'(GAIN_W);
    localparam logic [MUL_CNT_W-1:0] MUL2_STEPS = MUL_CNT_W'(STEP_W);

    // Command from the sequencer to the serial multiplier.
    typedef struct packed {
        logic                 start;
        logic                 hold_last;
        logic [MUL_CNT_W-1:0] steps;
    } t_mul_cmd;

    typedef logic [GAIN_W-1:0] t_sine_tab [SINE_DEPTH+1];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;

    // Sine over a quarter turn by a truncated Taylor series in Q30,
    // rounded half up to Q1.15 and clamped to unity.
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned mag;
        longint unsigned r;
        longint          acc;
        int              i;
        for (i = 0; i <= SINE_DEPTH; i++) begin
            x   = HALF_PI_Q30 * longint'(i) / SINE_DEPTH;
            x2  = (x * x) / Q30_ONE;
            mag = x;
            acc = longint'(x);
            // Each term is the previous one times x^2 over (2k)(2k+1), through x^13.
            mag = ((mag * x2) / Q30_ONE) / 64'd6;
            acc = acc - longint'(mag);
            mag = ((mag * x2) / Q30_ONE) / 64'd20;
            acc = acc + longint'(mag);
            mag = ((mag * x2) / Q30_ONE) / 64'd42;
            acc = acc - longint'(mag);
            mag = ((mag * x2) / Q30_ONE) / 64'd72;
            acc = acc + longint'(mag);
            mag = ((mag * x2) / Q30_ONE) / 64'd110;
            acc = acc - longint'(mag);
            mag = ((mag * x2) / Q30_ONE) / 64'd156;
            acc = acc + longint'(mag);
            if (acc < 0) begin
                acc = 0;
            end
            r = (longint'(acc) + 64'd16384) >> 15;
            if (r > 64'd32768) begin
                r = 64'd32768;
            end
            tab[i] = r[GAIN_W-1:0];
        end
        tab[SINE_DEPTH] = Q15_ONE;
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

[design/epcm_smul.sv]
// Bit-serial multiply-accumulate unit: two signed operands times two unsigned multipliers.
module epcm_smul #(
    parameter int ACC_W = 27
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  epcm_pkg::t_mul_cmd           i_cmd,
    input  logic signed [ACC_W-1:0]      i_x0,
    input  logic signed [ACC_W-1:0]      i_x1,
    input  logic [epcm_pkg::STEP_W-1:0]  i_m0,
    input  logic [epcm_pkg::STEP_W-1:0]  i_m1,
    output logic                         o_done,
    output logic signed [ACC_W-1:0]      o_acc
);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic                              r_hold_last, n_hold_last;
    logic [epcm_pkg::MUL_CNT_W-1:0]    r_cnt, n_cnt;
    logic [ACC_W-1:0]                  r_x0, n_x0;
    logic [ACC_W-1:0]                  r_x1, n_x1;
    logic [epcm_pkg::STEP_W-1:0]       r_m0, n_m0;
    logic [epcm_pkg::STEP_W-1:0]       r_m1, n_m1;
    logic [ACC_W-1:0]                  r_acc, n_acc;
    logic [ACC_W:0]                    s_sum;
    logic                              s_last;

    // Each step adds the selected operands at the current weight and halves, but for a last
    // step with hold_last set; the dropped bit makes the result a floor shift of the exact product.
    assign s_sum = {r_acc[ACC_W-1], r_acc}
                 + (r_m0[0] ? {r_x0[ACC_W-1], r_x0} : {(ACC_W+1){1'b0}})
                 + (r_m1[0] ? {r_x1[ACC_W-1], r_x1} : {(ACC_W+1){1'b0}});
    assign s_last = (r_cnt == epcm_pkg::MUL_CNT_W'(1));

    always_comb begin
        n_busy      = r_busy;
        n_done      = 1'b0;
        n_hold_last = r_hold_last;
        n_cnt       = r_cnt;
        n_x0        = r_x0;
        n_x1        = r_x1;
        n_m0        = r_m0;
        n_m1        = r_m1;
        n_acc       = r_acc;
        if (i_cmd.start) begin
            n_busy      = 1'b1;
            n_hold_last = i_cmd.hold_last;
            n_cnt       = i_cmd.steps;
            n_x0        = i_x0;
            n_x1        = i_x1;
            n_m0        = i_m0;
            n_m1        = i_m1;
            n_acc       = '0;
        end else if (r_busy) begin
            n_m0  = r_m0 >> 1;
            n_m1  = r_m1 >> 1;
            n_cnt = r_cnt - epcm_pkg::MUL_CNT_W'(1);
            if (s_last && r_hold_last) begin
                n_acc = s_sum[ACC_W-1:0];
            end else begin
                n_acc = s_sum[ACC_W:1];
            end
            if (s_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_hold_last <= n_hold_last;
        r_x0        <= n_x0;
        r_x1        <= n_x1;
        r_m0        <= n_m0;
        r_m1        <= n_m1;
        r_acc       <= n_acc;
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

[design/epcm_ctrl.sv]
// Mixer state, item sequencer, gain ramp, crossfade phase and the output register.
module epcm_ctrl #(
    parameter int SAMPLE_BITS = 24,
    parameter int ACC_W       = 27
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [epcm_pkg::OP_W-1:0]         i_opcode,
    input  logic signed [SAMPLE_BITS-1:0]     i_pad_a,
    input  logic signed [SAMPLE_BITS-1:0]     i_pad_b,
    input  logic signed [SAMPLE_BITS-1:0]     i_click,
    input  logic signed [SAMPLE_BITS-1:0]     i_accent,
    input  logic [epcm_pkg::STEP_W-1:0]       i_xfade_step,
    input  logic [epcm_pkg::STEP_W-1:0]       i_master_step,
    input  logic                              i_click_en,
    output epcm_pkg::t_mul_cmd                o_mul_cmd,
    output logic signed [ACC_W-1:0]           o_mul_x0,
    output logic signed [ACC_W-1:0]           o_mul_x1,
    output logic [epcm_pkg::STEP_W-1:0]       o_mul_m0,
    output logic [epcm_pkg::STEP_W-1:0]       o_mul_m1,
    input  logic                              i_mul_done,
    input  logic signed [ACC_W-1:0]           i_mul_acc,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_pad_out,
    output logic signed [SAMPLE_BITS-1:0]     o_click_out,
    output logic                              o_click_restart,
    output logic                              o_accent_restart,
    output logic                              o_playing,
    output logic                              o_crossfading
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_PHASE = 4'd2;
    localparam logic [3:0] S_TAB   = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_WAIT1 = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_WAIT2 = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam int XT_W = ACC_W - SAMPLE_BITS;
    localparam int SAT_W = ACC_W - SAMPLE_BITS + 1;

    logic [3:0]                          r_state, n_state;
    logic [epcm_pkg::OP_W-1:0]           r_op, n_op;
    logic [SAMPLE_BITS-1:0]              r_pad_a, n_pad_a;
    logic [SAMPLE_BITS-1:0]              r_pad_b, n_pad_b;
    logic [SAMPLE_BITS-1:0]              r_click, n_click;
    logic [SAMPLE_BITS-1:0]              r_accent, n_accent;
    logic [epcm_pkg::STEP_W-1:0]         r_master_gain, n_master_gain;
    logic                                r_fading_in, n_fading_in;
    logic                                r_fading_out, n_fading_out;
    logic                                r_playing, n_playing;
    logic                                r_fade_active, n_fade_active;
    logic                                r_side_b, n_side_b;
    logic [epcm_pkg::PHASE_W-1:0]        r_fade_phase, n_fade_phase;
    logic [epcm_pkg::GAIN_W-1:0]         r_gain_a, n_gain_a;
    logic [epcm_pkg::GAIN_W-1:0]         r_gain_b, n_gain_b;
    logic                                r_click_pend, n_click_pend;
    logic                                r_accent_pend, n_accent_pend;
    logic                                r_rs_click, n_rs_click;
    logic                                r_rs_accent, n_rs_accent;
    logic [epcm_pkg::SINE_IDX_W-1:0]     r_idx, n_idx;
    logic                                r_tab_ld, n_tab_ld;
    logic                                r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0]              r_pad_out, n_pad_out;
    logic [SAMPLE_BITS-1:0]              r_click_out, n_click_out;
    logic                                r_out_rs_click, n_out_rs_click;
    logic                                r_out_rs_accent, n_out_rs_accent;
    logic                                r_out_playing, n_out_playing;
    logic                                r_out_xfading, n_out_xfading;

    logic [epcm_pkg::STEP_W:0]           s_gain_up;
    logic [epcm_pkg::PHASE_SUM_W-1:0]    s_phase_sum;
    logic [epcm_pkg::SINE_AW-1:0]        s_sin_addr;
    logic [epcm_pkg::SINE_AW-1:0]        s_cos_addr;
    logic [epcm_pkg::GAIN_W-1:0]         s_sin;
    logic [epcm_pkg::GAIN_W-1:0]         s_cos;
    logic                                s_new_side;
    logic                                s_out_free;
    logic                                s_is_tick;
    logic [SAMPLE_BITS:0]                s_click_sum;
    logic [SAMPLE_BITS-1:0]              s_pad_sat;
    logic                                s_fits;

    assign s_gain_up   = {1'b0, r_master_gain} + {1'b0, i_master_step};
    assign s_phase_sum = epcm_pkg::PHASE_SUM_W'(r_fade_phase)
                       + epcm_pkg::PHASE_SUM_W'(i_xfade_step);
    assign s_sin_addr  = {1'b0, r_idx};
    assign s_cos_addr  = epcm_pkg::SINE_AW'(epcm_pkg::SINE_DEPTH) - s_sin_addr;
    assign s_sin       = epcm_pkg::SINE_TAB[s_sin_addr];
    assign s_cos       = epcm_pkg::SINE_TAB[s_cos_addr];
    assign s_new_side  = ~r_side_b;
    assign s_out_free  = !r_out_valid || i_out_ready;
    assign s_is_tick   = (r_op == epcm_pkg::OP_TICK);

    // Half of the click sum always fits the sample range.
    assign s_click_sum = {r_click[SAMPLE_BITS-1], r_click}
                       + {r_accent[SAMPLE_BITS-1], r_accent};

    assign s_fits    = (i_mul_acc[ACC_W-1:SAMPLE_BITS-1] == {SAT_W{i_mul_acc[ACC_W-1]}});
    assign s_pad_sat = s_fits ? i_mul_acc[SAMPLE_BITS-1:0]
                     : (i_mul_acc[ACC_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                           : {1'b0, {(SAMPLE_BITS-1){1'b1}}});

    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        n_pad_a         = r_pad_a;
        n_pad_b         = r_pad_b;
        n_click         = r_click;
        n_accent        = r_accent;
        n_master_gain   = r_master_gain;
        n_fading_in     = r_fading_in;
        n_fading_out    = r_fading_out;
        n_playing       = r_playing;
        n_fade_active   = r_fade_active;
        n_side_b        = r_side_b;
        n_fade_phase    = r_fade_phase;
        n_gain_a        = r_gain_a;
        n_gain_b        = r_gain_b;
        n_click_pend    = r_click_pend;
        n_accent_pend   = r_accent_pend;
        n_rs_click      = r_rs_click;
        n_rs_accent     = r_rs_accent;
        n_idx           = r_idx;
        n_tab_ld        = r_tab_ld;
        n_out_valid     = r_out_valid && !i_out_ready;
        n_pad_out       = r_pad_out;
        n_click_out     = r_click_out;
        n_out_rs_click  = r_out_rs_click;
        n_out_rs_accent = r_out_rs_accent;
        n_out_playing   = r_out_playing;
        n_out_xfading   = r_out_xfading;

        o_mul_cmd       = '0;
        o_mul_x0        = {{XT_W{r_pad_a[SAMPLE_BITS-1]}}, r_pad_a};
        o_mul_x1        = {{XT_W{r_pad_b[SAMPLE_BITS-1]}}, r_pad_b};
        o_mul_m0        = {{(epcm_pkg::STEP_W-epcm_pkg::GAIN_W){1'b0}}, r_gain_a};
        o_mul_m1        = {{(epcm_pkg::STEP_W-epcm_pkg::GAIN_W){1'b0}}, r_gain_b};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_opcode;
                    n_pad_a  = i_pad_a;
                    n_pad_b  = i_pad_b;
                    n_click  = i_click;
                    n_accent = i_accent;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_rs_click  = 1'b0;
                n_rs_accent = 1'b0;
                n_state     = S_DONE;
                unique case (r_op)
                    epcm_pkg::OP_PLAY: begin
                        n_playing    = 1'b1;
                        n_fading_in  = 1'b1;
                        n_fading_out = 1'b0;
                    end
                    epcm_pkg::OP_STOP: begin
                        n_fading_out = 1'b1;
                        n_fading_in  = 1'b0;
                    end
                    epcm_pkg::OP_XFADE: begin
                        if (!r_fade_active) begin
                            n_fade_phase  = '0;
                            n_fade_active = 1'b1;
                        end
                    end
                    epcm_pkg::OP_CLICK: begin
                        n_click_pend = 1'b1;
                    end
                    epcm_pkg::OP_ACCENT: begin
                        n_accent_pend = 1'b1;
                    end
                    epcm_pkg::OP_OPEN: begin
                        n_gain_a      = epcm_pkg::Q15_ONE;
                        n_gain_b      = '0;
                        n_side_b      = 1'b0;
                        n_fade_active = 1'b0;
                    end
                    epcm_pkg::OP_PRELOAD: begin
                        if (r_side_b) begin
                            n_gain_a = '0;
                        end else begin
                            n_gain_b = '0;
                        end
                    end
                    epcm_pkg::OP_TICK: begin
                        // Fade-in and fade-out never run together.
                        if (r_fading_in) begin
                            if (s_gain_up >= {1'b0, epcm_pkg::GAIN_ONE}) begin
                                n_master_gain = epcm_pkg::GAIN_ONE;
                                n_fading_in   = 1'b0;
                            end else begin
                                n_master_gain = s_gain_up[epcm_pkg::STEP_W-1:0];
                            end
                        end else if (r_fading_out) begin
                            if (r_master_gain <= i_master_step) begin
                                n_master_gain = '0;
                                n_fading_out  = 1'b0;
                                n_playing     = 1'b0;
                            end else begin
                                n_master_gain = r_master_gain - i_master_step;
                            end
                        end
                        n_rs_click    = r_click_pend;
                        n_rs_accent   = r_accent_pend;
                        n_click_pend  = 1'b0;
                        n_accent_pend = 1'b0;
                        n_state       = S_PHASE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_PHASE: begin
                n_tab_ld = 1'b0;
                if (r_playing && r_fade_active) begin
                    if (s_phase_sum >= epcm_pkg::PHASE_SUM_W'(epcm_pkg::PHASE_FULL)) begin
                        // End of the crossfade: the other side takes over fully.
                        n_fade_phase  = epcm_pkg::PHASE_FULL;
                        n_fade_active = 1'b0;
                        n_side_b      = s_new_side;
                        n_gain_a      = s_new_side ? '0 : epcm_pkg::Q15_ONE;
                        n_gain_b      = s_new_side ? epcm_pkg::Q15_ONE : '0;
                    end else begin
                        n_fade_phase = s_phase_sum[epcm_pkg::PHASE_W-1:0];
                        n_idx        = s_phase_sum[epcm_pkg::PHASE_BITS-1 -:
                                                   epcm_pkg::SINE_IDX_W];
                        n_tab_ld     = 1'b1;
                    end
                end
                n_state = S_TAB;
            end
            S_TAB: begin
                if (r_tab_ld) begin
                    n_gain_a = r_side_b ? s_sin : s_cos;
                    n_gain_b = r_side_b ? s_cos : s_sin;
                end
                n_state = r_playing ? S_MUL1 : S_DONE;
            end
            S_MUL1: begin
                o_mul_cmd.start     = 1'b1;
                o_mul_cmd.hold_last = 1'b1;
                o_mul_cmd.steps     = epcm_pkg::MUL1_STEPS;
                n_state             = S_WAIT1;
            end
            S_WAIT1: begin
                if (i_mul_done) begin
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                o_mul_cmd.start     = 1'b1;
                o_mul_cmd.hold_last = 1'b0;
                o_mul_cmd.steps     = epcm_pkg::MUL2_STEPS;
                o_mul_x0            = i_mul_acc;
                o_mul_x1            = '0;
                o_mul_m0            = r_master_gain;
                o_mul_m1            = '0;
                n_state             = S_WAIT2;
            end
            S_WAIT2: begin
                if (i_mul_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (s_out_free) begin
                    n_out_valid     = 1'b1;
                    n_pad_out       = (s_is_tick && r_playing) ? s_pad_sat : '0;
                    n_click_out     = (s_is_tick && i_click_en)
                                    ? s_click_sum[SAMPLE_BITS:1] : '0;
                    n_out_rs_click  = r_rs_click;
                    n_out_rs_accent = r_rs_accent;
                    n_out_playing   = r_playing;
                    n_out_xfading   = r_fade_active;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_master_gain <= '0;
            r_fading_in   <= 1'b0;
            r_fading_out  <= 1'b0;
            r_playing     <= 1'b0;
            r_fade_active <= 1'b0;
            r_side_b      <= 1'b0;
            r_fade_phase  <= '0;
            r_gain_a      <= epcm_pkg::Q15_ONE;
            r_gain_b      <= '0;
            r_click_pend  <= 1'b0;
            r_accent_pend <= 1'b0;
            r_tab_ld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_master_gain <= n_master_gain;
            r_fading_in   <= n_fading_in;
            r_fading_out  <= n_fading_out;
            r_playing     <= n_playing;
            r_fade_active <= n_fade_active;
            r_side_b      <= n_side_b;
            r_fade_phase  <= n_fade_phase;
            r_gain_a      <= n_gain_a;
            r_gain_b      <= n_gain_b;
            r_click_pend  <= n_click_pend;
            r_accent_pend <= n_accent_pend;
            r_tab_ld      <= n_tab_ld;
            r_out_valid   <= n_out_valid;
        end
        r_op            <= n_op;
        r_pad_a         <= n_pad_a;
        r_pad_b         <= n_pad_b;
        r_click         <= n_click;
        r_accent        <= n_accent;
        r_rs_click      <= n_rs_click;
        r_rs_accent     <= n_rs_accent;
        r_idx           <= n_idx;
        r_pad_out       <= n_pad_out;
        r_click_out     <= n_click_out;
        r_out_rs_click  <= n_out_rs_click;
        r_out_rs_accent <= n_out_rs_accent;
        r_out_playing   <= n_out_playing;
        r_out_xfading   <= n_out_xfading;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_pad_out        = r_pad_out;
    assign o_click_out      = r_click_out;
    assign o_click_restart  = r_out_rs_click;
    assign o_accent_restart = r_out_rs_accent;
    assign o_playing        = r_out_playing;
    assign o_crossfading    = r_out_xfading;

endmodule

[design/equal_power_crossfade_mixer.sv]
// Top level of the equal-power crossfade mixer with master fade ramp and click mix.
// Items: a command goes from input through execution to the output register; a tick also
// passes phase and table lookup, and a playing tick both serial products. The next input
// transfer can be taken once the result is in the output register. A playing tick runs
// the bit-serial multiplier for 16 steps for the gains and 25 for the master gain. Reset
// (synchronous, active low) restores the control state, the configuration registers and output valid.
module equal_power_crossfade_mixer #(
    parameter int SAMPLE_BITS = 24,
    localparam int IN_DATA_W  = ((4 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    // Input items.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pad_a_sample, pad_b_sample, click_sample, accent_sample (zero fill above)
    input  logic [IN_DATA_W-1:0]               s_axis_tdata,
    // opcode
    input  logic [epcm_pkg::OP_W-1:0]          s_axis_tuser,

    // Result items.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pad_out, click_out (zero fill above)
    output logic [OUT_DATA_W-1:0]              m_axis_tdata,
    // click_restart, accent_restart, playing, crossfading
    output logic [3:0]                         m_axis_tuser,

    // Configuration writes.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [epcm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [epcm_pkg::STEP_W-1:0]        i_cfg_data
);

    // The accumulator holds the pad sum and the gain products with headroom
    // for the signed sum of two weighted samples.
    localparam int ACC_W = SAMPLE_BITS + 3;

    logic [epcm_pkg::STEP_W-1:0]   r_xfade_step, n_xfade_step;
    logic [epcm_pkg::STEP_W-1:0]   r_master_step, n_master_step;
    logic                          r_click_en, n_click_en;

    epcm_pkg::t_mul_cmd            s_mul_cmd;
    logic signed [ACC_W-1:0]       s_mul_x0;
    logic signed [ACC_W-1:0]       s_mul_x1;
    logic [epcm_pkg::STEP_W-1:0]   s_mul_m0;
    logic [epcm_pkg::STEP_W-1:0]   s_mul_m1;
    logic                          s_mul_done;
    logic signed [ACC_W-1:0]       s_mul_acc;
    logic signed [SAMPLE_BITS-1:0] s_pad_out;
    logic signed [SAMPLE_BITS-1:0] s_click_out;
    logic                          s_click_restart;
    logic                          s_accent_restart;
    logic                          s_playing;
    logic                          s_crossfading;

    // The configuration channel never stalls. Writes take effect once registered, also
    // for an item in work; an index past the last register is dropped.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_xfade_step  = r_xfade_step;
        n_master_step = r_master_step;
        n_click_en    = r_click_en;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                epcm_pkg::CFG_XFADE_STEP:  n_xfade_step  = i_cfg_data;
                epcm_pkg::CFG_MASTER_STEP: n_master_step = i_cfg_data;
                epcm_pkg::CFG_CLICK_EN:    n_click_en    = i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xfade_step  <= epcm_pkg::XFADE_STEP_RST;
            r_master_step <= epcm_pkg::MASTER_STEP_RST;
            r_click_en    <= 1'b1;
        end else begin
            r_xfade_step  <= n_xfade_step;
            r_master_step <= n_master_step;
            r_click_en    <= n_click_en;
        end
    end

    // The sequencer owns all mixer state. It accepts one item at a time, walks
    // a tick through ramp, phase, table lookup and, while playing, the two serial
    // products, and parks the result in an output register so the next input
    // transfer can be taken while the downstream side is still stalled.
    epcm_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (s_axis_tvalid),
        .o_in_ready       (s_axis_tready),
        .i_opcode         (s_axis_tuser),
        .i_pad_a          (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_pad_b          (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_click          (s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .i_accent         (s_axis_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS]),
        .i_xfade_step     (r_xfade_step),
        .i_master_step    (r_master_step),
        .i_click_en       (r_click_en),
        .o_mul_cmd        (s_mul_cmd),
        .o_mul_x0         (s_mul_x0),
        .o_mul_x1         (s_mul_x1),
        .o_mul_m0         (s_mul_m0),
        .o_mul_m1         (s_mul_m1),
        .i_mul_done       (s_mul_done),
        .i_mul_acc        (s_mul_acc),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_pad_out        (s_pad_out),
        .o_click_out      (s_click_out),
        .o_click_restart  (s_click_restart),
        .o_accent_restart (s_accent_restart),
        .o_playing        (s_playing),
        .o_crossfading    (s_crossfading)
    );

    // One shared serial multiplier forms first the crossfaded pad sum, then
    // that sum times the master gain, one multiplier bit per cycle.
    epcm_smul #(
        .ACC_W (ACC_W)
    ) u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_mul_cmd),
        .i_x0    (s_mul_x0),
        .i_x1    (s_mul_x1),
        .i_m0    (s_mul_m0),
        .i_m1    (s_mul_m1),
        .o_done  (s_mul_done),
        .o_acc   (s_mul_acc)
    );

    assign m_axis_tdata = OUT_DATA_W'({s_click_out, s_pad_out});
    assign m_axis_tuser = {s_crossfading, s_playing, s_accent_restart, s_click_restart};

endmodule

[design/epcm_checker.sv]
// Port-level checks of the crossfade mixer and their attachment to the top level.
module epcm_checker #(
    parameter int SAMPLE_BITS = 24,
    parameter int OUT_DATA_W  = 48
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [3:0]            m_axis_tuser
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before transfer");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Pad output is silent whenever playback is off after the item.
    a_pad_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[SAMPLE_BITS-1:0] == '0)
        else $error("pad output while not playing");

    // Items are worked one at a time: no transfer right after a transfer.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

endmodule

bind equal_power_crossfade_mixer epcm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .OUT_DATA_W  (OUT_DATA_W)
) u_epcm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[test/tb_equal_power_crossfade_mixer.sv]
// Self-checking bench for the crossfade mixer: directed and random items against a predictor.
`timescale 1ns / 1ps

module tb_equal_power_crossfade_mixer;

    // Q24 unity for the master gain and the crossfade phase, Q1.15 unity for pad gains.
    localparam longint UNITY_Q24     = 64'd16777216;
    localparam int     UNITY_Q15     = 32768;
    localparam int     QUARTER_STEPS = 256;
    localparam longint SAMPLE_MAX    = 64'sd8388607;
    localparam longint SAMPLE_MIN    = -64'sd8388608;
    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     ITEMS_PER_PHASE = 325;

    // One expected result transfer.
    typedef struct packed {
        logic signed [23:0] pad;
        logic signed [23:0] clk;
        logic               click_rs;
        logic               accent_rs;
        logic               playing;
        logic               xfading;
    } t_mix_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // pad_a_sample, pad_b_sample, click_sample, accent_sample
    logic [95:0]                     s_axis_tdata;
    // opcode
    logic [epcm_pkg::OP_W-1:0]       s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // pad_out, click_out
    logic [47:0]                     m_axis_tdata;
    // click_restart, accent_restart, playing, crossfading
    logic [3:0]                      m_axis_tuser;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [epcm_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [epcm_pkg::STEP_W-1:0]     i_cfg_data;

    equal_power_crossfade_mixer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Expected results in transfer order, oldest at the front.
    t_mix_result mix_expect_q [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left = 0;

    // Predictor state: configuration copies and the mixer state.
    longint      xfade_inc;
    longint      ramp_inc;
    logic        click_on;
    longint      gain_level;
    logic        ramp_up;
    logic        ramp_down;
    logic        pad_active;
    logic        blend_busy;
    logic        on_side_b;
    longint      blend_pos;
    int          blend_gain_a;
    int          blend_gain_b;
    logic        click_armed;
    logic        accent_armed;
    int          sine_q15 [0:QUARTER_STEPS];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Quarter-wave sine in Q1.15 from a Taylor series through x^13 in Q30. Every
    // division truncates; the final value rounds half up and the top entry is unity.
    function automatic void fill_sine_q15();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint unsigned q15;
        for (int i = 0; i <= QUARTER_STEPS; i++) begin
            x    = 64'd1686629713 * longint'(i) / QUARTER_STEPS;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 6; k++) begin
                term = ((term * x2) >> 30) / (longint'(2 * k) * longint'(2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            q15 = (longint'(acc) + 64'd16384) >> 15;
            if (q15 > UNITY_Q15) begin
                q15 = UNITY_Q15;
            end
            sine_q15[i] = int'(q15);
        end
        sine_q15[QUARTER_STEPS] = UNITY_Q15;
    endfunction

    function automatic void reset_mixer_model();
        xfade_inc    = 175;
        ramp_inc     = 524;
        click_on     = 1'b1;
        gain_level   = 0;
        ramp_up      = 1'b0;
        ramp_down    = 1'b0;
        pad_active   = 1'b0;
        blend_busy   = 1'b0;
        on_side_b    = 1'b0;
        blend_pos    = 0;
        blend_gain_a = UNITY_Q15;
        blend_gain_b = 0;
        click_armed  = 1'b0;
        accent_armed = 1'b0;
    endfunction

    function automatic logic [23:0] clamp_sample(longint v);
        if (v > SAMPLE_MAX) begin
            return 24'h7F_FFFF;
        end
        if (v < SAMPLE_MIN) begin
            return 24'h80_0000;
        end
        return v[23:0];
    endfunction

    // Advances the predicted mixer by one item and returns the result it must give.
    function automatic t_mix_result advance_mixer(logic [epcm_pkg::OP_W-1:0] op,
                                                  logic signed [23:0] pad_a,
                                                  logic signed [23:0] pad_b,
                                                  logic signed [23:0] click_s,
                                                  logic signed [23:0] accent_s);
        t_mix_result res;
        longint      mix;
        longint      idx;
        res = '0;
        case (op)
            epcm_pkg::OP_PLAY: begin
                pad_active = 1'b1;
                ramp_up    = 1'b1;
                ramp_down  = 1'b0;
            end
            epcm_pkg::OP_STOP: begin
                ramp_down = 1'b1;
                ramp_up   = 1'b0;
            end
            epcm_pkg::OP_XFADE: begin
                // A crossfade request during a running crossfade changes nothing.
                if (!blend_busy) begin
                    blend_pos  = 0;
                    blend_busy = 1'b1;
                end
            end
            epcm_pkg::OP_CLICK:  click_armed  = 1'b1;
            epcm_pkg::OP_ACCENT: accent_armed = 1'b1;
            epcm_pkg::OP_OPEN: begin
                blend_gain_a = UNITY_Q15;
                blend_gain_b = 0;
                on_side_b    = 1'b0;
                blend_busy   = 1'b0;
            end
            epcm_pkg::OP_PRELOAD: begin
                if (on_side_b) begin
                    blend_gain_a = 0;
                end else begin
                    blend_gain_b = 0;
                end
            end
            epcm_pkg::OP_TICK: begin
                if (ramp_up) begin
                    gain_level = gain_level + ramp_inc;
                    if (gain_level >= UNITY_Q24) begin
                        gain_level = UNITY_Q24;
                        ramp_up    = 1'b0;
                    end
                end
                if (ramp_down) begin
                    // Fading out to zero stops playback on this very tick.
                    if (gain_level <= ramp_inc) begin
                        gain_level = 0;
                        ramp_down  = 1'b0;
                        pad_active = 1'b0;
                    end else begin
                        gain_level = gain_level - ramp_inc;
                    end
                end
                if (pad_active) begin
                    if (blend_busy) begin
                        blend_pos = blend_pos + xfade_inc;
                        if (blend_pos >= UNITY_Q24) begin
                            // Crossfade done: the other side takes over at unity.
                            blend_pos    = UNITY_Q24;
                            blend_busy   = 1'b0;
                            on_side_b    = !on_side_b;
                            blend_gain_a = on_side_b ? 0 : UNITY_Q15;
                            blend_gain_b = on_side_b ? UNITY_Q15 : 0;
                        end else begin
                            idx          = (blend_pos * QUARTER_STEPS) >> 24;
                            blend_gain_a = on_side_b ? sine_q15[idx]
                                                     : sine_q15[QUARTER_STEPS - idx];
                            blend_gain_b = on_side_b ? sine_q15[QUARTER_STEPS - idx]
                                                     : sine_q15[idx];
                        end
                    end
                    mix = longint'(pad_a) * longint'(blend_gain_a)
                        + longint'(pad_b) * longint'(blend_gain_b);
                    mix = (mix >>> 15) * gain_level;
                    res.pad = clamp_sample(mix >>> 25);
                end
                res.click_rs  = click_armed;
                res.accent_rs = accent_armed;
                click_armed   = 1'b0;
                accent_armed  = 1'b0;
                if (click_on) begin
                    res.clk = clamp_sample((longint'(click_s) + longint'(accent_s)) >>> 1);
                end
            end
            default: ;
        endcase
        res.playing = pad_active;
        res.xfading = blend_busy;
        return res;
    endfunction

    // The receiver either holds off for a requested stretch or stalls at random.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left     = hold_left - 1;
        end else begin
            m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Every result transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_mix_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (mix_expect_q.size() == 0) begin
                $display("%0t ns: result with nothing expected, expected none, actual %h %h",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = mix_expect_q.pop_front();
                check_field("pad_out", want.pad, $signed(m_axis_tdata[23:0]));
                check_field("click_out", want.clk, $signed(m_axis_tdata[47:24]));
                check_field("click_restart", want.click_rs, m_axis_tuser[0]);
                check_field("accent_restart", want.accent_rs, m_axis_tuser[1]);
                check_field("playing", want.playing, m_axis_tuser[2]);
                check_field("crossfading", want.xfading, m_axis_tuser[3]);
            end
        end
    end

    // Offers one item, waits for its transfer and records the predicted result.
    // Called and returning at a falling edge.
    task automatic send_item(input logic [epcm_pkg::OP_W-1:0] op,
                             input logic signed [23:0] pad_a,
                             input logic signed [23:0] pad_b,
                             input logic signed [23:0] click_s,
                             input logic signed [23:0] accent_s);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {accent_s, click_s, pad_b, pad_a};
        s_axis_tuser  = op;
        do @(posedge i_clk); while (!s_axis_tready);
        mix_expect_q.push_back(advance_mixer(op, pad_a, pad_b, click_s, accent_s));
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Sender pause: nothing more goes in until every expected result has come.
    task automatic drain_results();
        while (mix_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [epcm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [epcm_pkg::STEP_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            epcm_pkg::CFG_XFADE_STEP:  xfade_inc = value;
            epcm_pkg::CFG_MASTER_STEP: ramp_inc  = value;
            epcm_pkg::CFG_CLICK_EN:    click_on  = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Registers change only with the mixer idle. The click enable write carries
    // random upper bits, which the block must ignore.
    task automatic configure(input logic [epcm_pkg::STEP_W-1:0] xf,
                             input logic [epcm_pkg::STEP_W-1:0] ms,
                             input logic ce);
        logic [epcm_pkg::STEP_W-1:0] ce_word;
        ce_word    = epcm_pkg::STEP_W'($urandom);
        ce_word[0] = ce;
        drain_results();
        write_reg(epcm_pkg::CFG_XFADE_STEP, xf);
        write_reg(epcm_pkg::CFG_MASTER_STEP, ms);
        write_reg(epcm_pkg::CFG_CLICK_EN, ce_word);
    endtask

    function automatic logic [epcm_pkg::STEP_W-1:0] mid_step();
        return epcm_pkg::STEP_W'($urandom_range(1 << 22, 1 << 16));
    endfunction

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(9))
            0:       return 24'h7F_FFFF;
            1:       return 24'h80_0000;
            default: return 24'($urandom);
        endcase
    endfunction

    // Mostly ticks, with commands mixed in; a stopped pad is restarted often so
    // that ramps and crossfades get exercised while playing.
    task automatic send_random_item();
        logic [epcm_pkg::OP_W-1:0] op;
        int                        r;
        r = $urandom_range(99);
        if (r < 55) begin
            op = epcm_pkg::OP_TICK;
        end else if (r < 62) begin
            op = epcm_pkg::OP_PLAY;
        end else if (r < 67) begin
            op = epcm_pkg::OP_STOP;
        end else if (r < 75) begin
            op = epcm_pkg::OP_XFADE;
        end else if (r < 82) begin
            op = epcm_pkg::OP_CLICK;
        end else if (r < 87) begin
            op = epcm_pkg::OP_ACCENT;
        end else if (r < 92) begin
            op = epcm_pkg::OP_OPEN;
        end else begin
            op = epcm_pkg::OP_PRELOAD;
        end
        if (!pad_active && $urandom_range(3) == 0) begin
            op = epcm_pkg::OP_PLAY;
        end
        send_item(op, pick_sample(), pick_sample(), pick_sample(), pick_sample());
    endtask

    task automatic test_directed();
        // Idle mixer: extreme samples give no pad output; the click mix still runs.
        send_item(epcm_pkg::OP_TICK, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF);
        send_item(epcm_pkg::OP_TICK, 24'h80_0000, 24'h80_0000, 24'h80_0000, 24'h80_0000);
        // Pending triggers are held across commands and emitted on the next tick.
        send_item(epcm_pkg::OP_CLICK, 24'h12_3456, 0, 0, 0);
        send_item(epcm_pkg::OP_ACCENT, 0, 0, 0, 0);
        send_item(epcm_pkg::OP_TICK, 24'h00_0001, 24'hFF_FFFF, 24'h7F_FFFF, 24'h80_0000);
        send_item(epcm_pkg::OP_PLAY, 0, 0, 0, 0);
        send_item(epcm_pkg::OP_TICK, 24'h7F_FFFF, 24'h80_0000, 24'h00_0000, 24'hFF_FFFF);
        send_item(epcm_pkg::OP_TICK, 24'h80_0000, 24'h7F_FFFF, 24'h40_0000, 24'h40_0000);

        // Fast steps: the ramp reaches unity at once and a crossfade takes four ticks.
        configure(25'h40_0000, 25'h100_0000, 1'b0);
        send_item(epcm_pkg::OP_CLICK, 0, 0, 0, 0);
        send_item(epcm_pkg::OP_TICK, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF);
        send_item(epcm_pkg::OP_XFADE, 0, 0, 0, 0);
        send_item(epcm_pkg::OP_XFADE, 0, 0, 0, 0);
        repeat (4) begin
            send_item(epcm_pkg::OP_TICK, 24'h80_0000, 24'h80_0000, 24'h55_5555, 24'hAA_AAAA);
        end
        // Now on side B: preloading clears side A, then a new crossfade is cut short.
        send_item(epcm_pkg::OP_PRELOAD, 0, 0, 0, 0);
        send_item(epcm_pkg::OP_XFADE, 0, 0, 0, 0);
        send_item(epcm_pkg::OP_TICK, 24'h7F_FFFF, 24'h80_0000, 0, 0);
        send_item(epcm_pkg::OP_OPEN, 0, 0, 0, 0);
        send_item(epcm_pkg::OP_TICK, 24'h7F_FFFF, 24'h80_0000, 0, 0);
        // Fade-out reaching zero ends playback on that same tick.
        send_item(epcm_pkg::OP_STOP, 0, 0, 0, 0);
        send_item(epcm_pkg::OP_TICK, 24'h7F_FFFF, 24'h7F_FFFF, 0, 0);
        send_item(epcm_pkg::OP_TICK, 24'h7F_FFFF, 24'h7F_FFFF, 0, 0);
    endtask

    task automatic test_random_phase(input int count, input logic [epcm_pkg::STEP_W-1:0] xf,
                                     input logic [epcm_pkg::STEP_W-1:0] ms, input logic ce);
        configure(xf, ms, ce);
        repeat (count) begin
            send_random_item();
        end
    endtask

    // The receiver stops for a long stretch while items keep coming, so the
    // block has to fill up and hold its input off.
    task automatic test_backpressure();
        int saved_idle;
        saved_idle = send_idle_pct;
        configure(mid_step(), mid_step(), 1'b1);
        send_idle_pct = 0;
        @(posedge i_clk);
        hold_left = 400;
        @(negedge i_clk);
        send_item(epcm_pkg::OP_PLAY, 0, 0, 0, 0);
        repeat (30) begin
            send_random_item();
        end
        send_idle_pct = saved_idle;
        drain_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = epcm_pkg::OP_TICK;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = epcm_pkg::CFG_XFADE_STEP;
        i_cfg_data    = '0;
        fill_sine_q15();
        reset_mixer_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();

        // Sender idles less than the receiver, then the other way round, then neither.
        send_idle_pct = 38;
        recv_idle_pct = 62;
        test_random_phase(ITEMS_PER_PHASE, mid_step(), mid_step(), 1'b1);
        test_random_phase(ITEMS_PER_PHASE, 25'd1, 25'h100_0000, 1'b0);
        send_idle_pct = 62;
        recv_idle_pct = 38;
        test_random_phase(ITEMS_PER_PHASE, 25'h100_0000, 25'd1, 1'b1);
        // A zero crossfade step leaves a started crossfade running until an open command ends it.
        test_random_phase(ITEMS_PER_PHASE, 25'd0, mid_step(), 1'b1);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // A zero master step freezes the ramp wherever it stands.
        test_random_phase(ITEMS_PER_PHASE, mid_step(), 25'd0, 1'b0);
        test_random_phase(ITEMS_PER_PHASE, mid_step(), mid_step(), 1'b1);

        drain_results();
        // Any extra result after the drain would show up here.
        repeat (60) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[equal_power_crossfade_mixer.f]
design/epcm_pkg.sv
design/epcm_smul.sv
design/epcm_ctrl.sv
design/equal_power_crossfade_mixer.sv
design/epcm_checker.sv
test/tb_equal_power_crossfade_mixer.sv
